// ===== rtl/core/multi_pattern_matcher_assert.svh =====
// Assertion macros shared by the matcher RTL.
`ifndef MULTI_PATTERN_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matcher assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matcher assertion failed");

`endif

// ===== rtl/core/mpm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpm_pkg
// Field widths and command codes of the multi-pattern matcher.
// ----------------------------------------------------------------------------
package mpm_pkg;

    localparam int KIND_W = 3;
    localparam int SYM_W  = 5;
    localparam int PID_W  = 10;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind K_LETTER = 3'd0;
    localparam t_kind K_END    = 3'd1;
    localparam t_kind K_BUILD  = 3'd2;
    localparam t_kind K_TEXT   = 3'd3;
    localparam t_kind K_READ   = 3'd4;
    localparam t_kind K_CLEAR  = 3'd5;

endpackage

// ===== rtl/core/mpm_addr_unit.sv =====
// ----------------------------------------------------------------------------
// mpm_addr_unit
// Shared goto-table address generator: node * alphabet + letter, registered.
// ----------------------------------------------------------------------------
module mpm_addr_unit #(
    parameter int ALPHABET = 26,
    parameter int NODE_W   = 12,
    parameter int AW       = 5,
    parameter int GA_W     = 17
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [NODE_W-1:0] i_node,
    input  logic [AW-1:0]     i_letter,
    output logic [GA_W-1:0]   o_addr
);

    logic [GA_W-1:0] r_addr;
    logic [GA_W-1:0] n_addr;

    assign n_addr = GA_W'(i_node) * GA_W'(ALPHABET) + GA_W'(i_letter);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addr <= n_addr;
        end
    end

    assign o_addr = r_addr;

endmodule

// ===== rtl/core/multi_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_matcher
// Aho-Corasick engine: trie insert, breadth-first link build, text scan, match
// query and clear, all run by one sequencer around a shared address unit.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+---------------------------
// command   | in        | i_start, o_busy              | i_kind, i_symbol, i_pattern_id
// answer    | out       | o_valid (one-cycle strobe)   | o_matched, o_table_full
//
// A command transfer happens on a rising edge with i_start high and o_busy low.
// End and ignored commands return straight to idle; a read passes through S_RD1
// and S_RD2, and the answer strobe is registered in S_RD2. A pattern letter reads
// the goto table and, when it allocates a node, zeroes the node's goto row through
// the single write port. A text letter steps to each node on the failure chain and
// marks it seen. Build scans the root row, then for each trie node and letter reads
// the goto table for the node and for its failure target through the one read port.
// After reset and after a clear command, a clearing pass empties the pattern tag
// table and the root's goto row and node entries; o_busy is high meanwhile. The
// answer strobe cannot be stalled by the receiver.
//
module multi_pattern_matcher
    import mpm_pkg::*;
#(
    parameter int MAX_NODES    = 4096,
    parameter int ALPHABET     = 26,
    parameter int MAX_PATTERNS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic [PID_W-1:0] i_pattern_id,
    output logic             o_valid,
    output logic             o_matched,
    output logic             o_table_full
);

    `include "multi_pattern_matcher_assert.svh"

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int AW      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int GDEPTH  = MAX_NODES * ALPHABET;
    localparam int GA_W    = $clog2(GDEPTH);
    localparam int TW      = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CLR_LEN = (MAX_PATTERNS > ALPHABET) ? MAX_PATTERNS : ALPHABET;
    localparam int CW      = $clog2(CLR_LEN + 1);

    // One-hot sequencer states.
    typedef enum logic [22:0] {
        S_CLR    = 23'd1 << 0,
        S_IDLE   = 23'd1 << 1,
        S_INS_RD = 23'd1 << 2,
        S_INS_CK = 23'd1 << 3,
        S_ZA     = 23'd1 << 4,
        S_ZW     = 23'd1 << 5,
        S_RA     = 23'd1 << 6,
        S_RRD    = 23'd1 << 7,
        S_RCK    = 23'd1 << 8,
        S_POP    = 23'd1 << 9,
        S_BU     = 23'd1 << 10,
        S_BF     = 23'd1 << 11,
        S_CA1    = 23'd1 << 12,
        S_CR1    = 23'd1 << 13,
        S_CA2    = 23'd1 << 14,
        S_CR2    = 23'd1 << 15,
        S_CDO    = 23'd1 << 16,
        S_TRD    = 23'd1 << 17,
        S_TGO    = 23'd1 << 18,
        S_TMARK  = 23'd1 << 19,
        S_TNEXT  = 23'd1 << 20,
        S_RD1    = 23'd1 << 21,
        S_RD2    = 23'd1 << 22
    } t_state;

    t_state r_state, n_state;

    // Tables. Goto rows and node entries are zeroed when a node is allocated, so only
    // the root row, the root's node entries and the tag table need the clearing pass.
    logic [NODE_W-1:0] goto_mem [GDEPTH];
    logic [NODE_W-1:0] fail_mem [MAX_NODES];
    logic              seen_mem [MAX_NODES];
    logic [NODE_W:0]   term_mem [MAX_PATTERNS];
    logic [NODE_W-1:0] queue_mem [MAX_NODES];

    logic [NODE_W-1:0] r_node_count, r_ins_cur, r_txt_cur;
    logic              r_overflow, r_built;
    logic [NODE_W:0]   r_head, r_tail;
    logic [AW-1:0]     r_letter;
    logic [CW-1:0]     r_clr;
    logic [NODE_W-1:0] r_u, r_fu, r_v, r_j;
    logic [GA_W-1:0]   r_wa;
    logic [NODE_W-1:0] r_gdata, r_fdata, r_qdata;
    logic [NODE_W:0]   r_tdata;
    logic              r_sdata, r_idok, r_mv;
    logic              r_valid, r_matched, r_full;

    logic              addr_load;
    logic [NODE_W-1:0] addr_node;
    logic [AW-1:0]     addr_letter;
    logic [GA_W-1:0]   gaddr;

    logic              g_we;
    logic [GA_W-1:0]   g_wa;
    logic [NODE_W-1:0] g_wd;
    logic              f_we;
    logic [NODE_W-1:0] f_wa, f_wd, f_ra;
    logic              s_we, s_wd;
    logic [NODE_W-1:0] s_wa;

    logic              sym_ok, id_ok, accept, letter_last, tail_room;
    logic [NODE_W:0]   next_node;

    assign accept      = i_start && (r_state == S_IDLE) && i_rst_n;
    assign sym_ok      = 32'(i_symbol) < ALPHABET;
    assign id_ok       = 32'(i_pattern_id) < MAX_PATTERNS;
    assign letter_last = 32'(r_letter) == (ALPHABET - 1);
    assign tail_room   = r_tail < (NODE_W + 1)'(MAX_NODES);
    assign next_node   = {1'b0, r_node_count} + 1'b1;

    mpm_addr_unit #(
        .ALPHABET (ALPHABET),
        .NODE_W   (NODE_W),
        .AW       (AW),
        .GA_W     (GA_W)
    ) u_addr (
        .i_clk    (i_clk),
        .i_load   (addr_load),
        .i_node   (addr_node),
        .i_letter (addr_letter),
        .o_addr   (gaddr)
    );

    // Operand selection for the shared address unit.
    always_comb begin
        addr_load   = 1'b0;
        addr_node   = '0;
        addr_letter = r_letter;
        unique case (r_state)
            S_IDLE: begin
                addr_load   = 1'b1;
                addr_letter = AW'(i_symbol);
                addr_node   = (i_kind == K_TEXT) ? r_txt_cur : r_ins_cur;
            end
            S_ZA:    begin addr_load = 1'b1; addr_node = r_ins_cur; end
            S_RA:    begin addr_load = 1'b1; addr_node = '0;        end
            S_CA1:   begin addr_load = 1'b1; addr_node = r_u;       end
            S_CA2:   begin addr_load = 1'b1; addr_node = r_fu;      end
            default: begin addr_load = 1'b0;                        end
        endcase
    end

    // Table write ports.
    always_comb begin
        g_we = 1'b0; g_wa = gaddr; g_wd = '0;
        f_we = 1'b0; f_wa = '0;    f_wd = '0;
        s_we = 1'b0; s_wa = '0;    s_wd = 1'b0;
        unique case (r_state)
            S_CLR: begin
                g_wa = GA_W'(r_clr);
                g_we = 32'(r_clr) < ALPHABET;
                f_we = (r_clr == '0);
                s_we = (r_clr == '0);
            end
            S_INS_CK: begin
                if (r_gdata == '0 && 32'(next_node) < MAX_NODES) begin
                    g_we = 1'b1;
                    g_wd = next_node[NODE_W-1:0];
                    f_we = 1'b1;
                    f_wa = next_node[NODE_W-1:0];
                    s_we = 1'b1;
                    s_wa = next_node[NODE_W-1:0];
                end
            end
            S_ZW: g_we = 1'b1;
            S_CDO: begin
                if (r_v != '0) begin
                    f_we = 1'b1;
                    f_wa = r_v;
                    f_wd = r_gdata;
                end else begin
                    g_we = 1'b1;
                    g_wa = r_wa;
                    g_wd = r_gdata;
                end
            end
            S_TMARK: begin
                s_we = (r_j != '0);
                s_wa = r_j;
                s_wd = 1'b1;
            end
            default: g_we = 1'b0;
        endcase
    end

    assign f_ra = (r_state == S_BU) ? r_qdata : r_j;

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            goto_mem[g_wa] <= g_wd;
        end
        r_gdata <= goto_mem[gaddr];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            fail_mem[f_wa] <= f_wd;
        end
        r_fdata <= fail_mem[f_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            seen_mem[s_wa] <= s_wd;
        end
        r_sdata <= seen_mem[r_tdata[NODE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR && 32'(r_clr) < MAX_PATTERNS) begin
            term_mem[TW'(r_clr)] <= '0;
        end else if (accept && i_kind == K_END && !r_overflow && !r_built && id_ok) begin
            term_mem[TW'(i_pattern_id)] <= {1'b1, r_ins_cur};
        end
        r_tdata <= term_mem[TW'(i_pattern_id)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RCK && r_gdata != '0 && tail_room) begin
            queue_mem[r_tail[NODE_W-1:0]] <= r_gdata;
        end else if (r_state == S_CDO && r_v != '0 && tail_room) begin
            queue_mem[r_tail[NODE_W-1:0]] <= r_v;
        end
        r_qdata <= queue_mem[r_head[NODE_W-1:0]];
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:    if (32'(r_clr) == CLR_LEN - 1) n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    priority if (i_kind == K_LETTER && !r_overflow && !r_built && sym_ok)
                        n_state = S_INS_RD;
                    else if (i_kind == K_BUILD && !r_built)
                        n_state = S_RA;
                    else if (i_kind == K_TEXT && sym_ok)
                        n_state = S_TRD;
                    else if (i_kind == K_READ)
                        n_state = S_RD1;
                    else if (i_kind == K_CLEAR)
                        n_state = S_CLR;
                    else
                        n_state = S_IDLE;
                end
            end
            S_INS_RD: n_state = S_INS_CK;
            S_INS_CK: n_state = (r_gdata == '0 && 32'(next_node) < MAX_NODES) ? S_ZA : S_IDLE;
            S_ZA:     n_state = S_ZW;
            S_ZW:     n_state = letter_last ? S_IDLE : S_ZA;
            S_RA:     n_state = S_RRD;
            S_RRD:    n_state = S_RCK;
            S_RCK:    n_state = letter_last ? S_POP : S_RA;
            S_POP:    n_state = (r_head == r_tail) ? S_IDLE : S_BU;
            S_BU:     n_state = S_BF;
            S_BF:     n_state = S_CA1;
            S_CA1:    n_state = S_CR1;
            S_CR1:    n_state = S_CA2;
            S_CA2:    n_state = S_CR2;
            S_CR2:    n_state = S_CDO;
            S_CDO:    n_state = letter_last ? S_POP : S_CA1;
            S_TRD:    n_state = S_TGO;
            S_TGO:    n_state = S_TMARK;
            S_TMARK:  n_state = (r_j == '0) ? S_IDLE : S_TNEXT;
            S_TNEXT:  n_state = S_TMARK;
            S_RD1:    n_state = S_RD2;
            S_RD2:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_node_count <= '0;
            r_ins_cur    <= '0;
            r_txt_cur    <= '0;
            r_overflow   <= 1'b0;
            r_built      <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_clr    <= '0;
                    r_letter <= '0;
                    if (i_start) begin
                        unique case (i_kind)
                            K_END: begin
                                if (!r_overflow && !r_built) r_ins_cur <= '0;
                            end
                            K_BUILD: begin
                                r_built <= 1'b1;
                                r_head  <= '0;
                                r_tail  <= '0;
                            end
                            K_READ: r_idok <= id_ok;
                            K_CLEAR: begin
                                r_node_count <= '0;
                                r_ins_cur    <= '0;
                                r_txt_cur    <= '0;
                                r_overflow   <= 1'b0;
                                r_built      <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INS_CK: begin
                    if (r_gdata != '0) begin
                        r_ins_cur <= r_gdata;
                    end else if (32'(next_node) < MAX_NODES) begin
                        r_node_count <= next_node[NODE_W-1:0];
                        r_ins_cur    <= next_node[NODE_W-1:0];
                    end else begin
                        r_overflow <= 1'b1;
                    end
                end
                S_ZW:  r_letter <= r_letter + 1'b1;
                S_RCK: begin
                    if (r_gdata != '0 && tail_room) r_tail <= r_tail + 1'b1;
                    r_letter <= letter_last ? '0 : r_letter + 1'b1;
                end
                S_POP: if (r_head != r_tail) r_head <= r_head + 1'b1;
                S_BU:  r_u <= r_qdata;
                S_BF: begin
                    r_fu     <= r_fdata;
                    r_letter <= '0;
                end
                S_CA2: begin
                    r_v  <= r_gdata;
                    r_wa <= gaddr;
                end
                S_CDO: begin
                    if (r_v != '0 && tail_room) r_tail <= r_tail + 1'b1;
                    r_letter <= r_letter + 1'b1;
                end
                S_TGO: begin
                    r_txt_cur <= r_gdata;
                    r_j       <= r_gdata;
                end
                S_TNEXT: r_j <= r_fdata;
                S_RD1:   r_mv <= r_idok && r_tdata[NODE_W];
                S_RD2: begin
                    r_valid   <= 1'b1;
                    r_matched <= r_mv && r_sdata;
                    r_full    <= r_overflow;
                end
                default: r_clr <= r_clr;
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid      = r_valid;
    assign o_matched    = r_matched;
    assign o_table_full = r_full;

    `MPM_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `MPM_ASSERT_NOW(a_read_answers, i_clk, i_rst_n, i_start && !o_busy && i_kind == K_READ, ##3 o_valid)
    `MPM_ASSERT_NOW(a_strobe_from_read, i_clk, i_rst_n, o_valid, $past(r_state == S_RD2))
    `MPM_ASSERT_NOW(a_cursor_in_trie, i_clk, i_rst_n, 1'b1, r_ins_cur <= r_node_count)

endmodule
